>>> hdl/ir_remote_rgb_dimmer_macros.svh
// Assertion helpers shared by the dimmer RTL.
// Each helper is clocked on the rising edge and is quiet while reset is high.
`ifndef IR_REMOTE_RGB_DIMMER_MACROS_SVH
`define IR_REMOTE_RGB_DIMMER_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every edge.
`define IRRD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define IRRD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define IRRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IRRD_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define IRRD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define IRRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/irrd_pkg.sv
`timescale 1ns / 1ps
package irrd_pkg;

  // Field widths
  localparam int EDGE_W      = 16;
  localparam int LEVEL_W     = 16;
  localparam int CODE_W      = 32;
  localparam int CFG_W       = 16;
  localparam int BIT_CNT_W   = $clog2(CODE_W);
  localparam int REG_COUNT   = 8;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int APB_DATA_W  = 32;

  // Queue between decoder and level unit
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map, index in units of one 32-bit word
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PERIOD_TOP = 3'd0,
    REG_STEP_SIZE  = 3'd1,
    REG_START_MIN  = 3'd2,
    REG_START_MAX  = 3'd3,
    REG_ONE_MIN    = 3'd4,
    REG_ONE_MAX    = 3'd5,
    REG_ZERO_MIN   = 3'd6,
    REG_ZERO_MAX   = 3'd7
  } irrd_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] period_top;
    logic [CFG_W-1:0] step_size;
    logic [CFG_W-1:0] start_min;
    logic [CFG_W-1:0] start_max;
    logic [CFG_W-1:0] one_min;
    logic [CFG_W-1:0] one_max;
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
  } irrd_cfg_t;

  localparam irrd_cfg_t CFG_RESET = '{
    period_top: 16'd20000,
    step_size:  16'd2000,
    start_min:  16'd11000,
    start_max:  16'd15000,
    one_min:    16'd1800,
    one_max:    16'd2800,
    zero_min:   16'd700,
    zero_max:   16'd1600
  };

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd20000;

  // Remote key codes, first received bit in bit 0
  localparam logic [CODE_W-1:0] KEY_RED_DOWN   = 32'hBA45FF00;
  localparam logic [CODE_W-1:0] KEY_RED_UP     = 32'hBB44FF00;
  localparam logic [CODE_W-1:0] KEY_GREEN_DOWN = 32'hB946FF00;
  localparam logic [CODE_W-1:0] KEY_GREEN_UP   = 32'hBF40FF00;
  localparam logic [CODE_W-1:0] KEY_BLUE_DOWN  = 32'hB847FF00;
  localparam logic [CODE_W-1:0] KEY_BLUE_UP    = 32'hBC43FF00;
  localparam logic [CODE_W-1:0] KEY_ALL_MAX    = 32'hF20DFF00;
  localparam logic [CODE_W-1:0] KEY_ALL_ZERO   = 32'hE916FF00;
  localparam logic [CODE_W-1:0] CODE_ALL_ONES  = 32'hFFFFFFFF;

  // Decoder result handed to the level unit
  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] code;
  } irrd_cmd_t;

endpackage

>>> hdl/irrd_ifs.sv
`timescale 1ns / 1ps
// Capture timestamp channel
interface irrd_edge_if import irrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink (input valid, input edge_time, output ready);
endinterface

// Level and code result channel
interface irrd_result_if import irrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;
  logic               code_done;
  logic [CODE_W-1:0]  code_value;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  output code_done, output code_value, input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                input code_done, input code_value, output ready);
endinterface

>>> hdl/irrd_front.sv
`timescale 1ns / 1ps
`include "ir_remote_rgb_dimmer_macros.svh"
module irrd_front import irrd_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  irrd_cfg_t    cfg,
  irrd_edge_if.sink    edge_ch,
  output logic         push_valid,
  output irrd_cmd_t    push_cmd,
  input  logic         push_ready
);

  logic [EDGE_W-1:0]     last_edge;
  logic [BIT_CNT_W-1:0]  bit_count;
  logic [CODE_W-1:0]     shift_code;
  logic                  receiving;

  logic [BIT_CNT_W-1:0]  bit_count_next;
  logic [CODE_W-1:0]     shift_code_next;
  logic                  receiving_next;
  logic                  done;
  logic                  bit_in;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] last_t;
  logic [TIME_WIDTH-1:0] top_t;
  logic [TIME_WIDTH-1:0] delta;
  logic                  is_start;
  logic                  is_one;
  logic                  is_zero;
  logic                  accept;

  // Pass queue backpressure straight to the capture channel
  assign edge_ch.ready = push_ready;
  assign push_valid    = edge_ch.valid;
  assign accept        = edge_ch.valid && push_ready;

  // Form the interval, wrapping at the timer period
  assign now_t  = TIME_WIDTH'(edge_ch.edge_time);
  assign last_t = TIME_WIDTH'(last_edge);
  assign top_t  = TIME_WIDTH'(cfg.period_top);
  assign delta  = (edge_ch.edge_time >= last_edge) ? (now_t - last_t)
                                                   : (top_t - last_t + now_t);

  // Classify against the open windows
  assign is_start = (delta > TIME_WIDTH'(cfg.start_min)) && (delta < TIME_WIDTH'(cfg.start_max));
  assign is_one   = (delta > TIME_WIDTH'(cfg.one_min)) && (delta < TIME_WIDTH'(cfg.one_max));
  assign is_zero  = (delta > TIME_WIDTH'(cfg.zero_min)) && (delta < TIME_WIDTH'(cfg.zero_max));

  // Advance the frame state
  always_comb begin
    bit_count_next  = bit_count;
    shift_code_next = shift_code;
    receiving_next  = receiving;
    done            = 1'b0;
    bit_in          = 1'b0;
    if (is_start) begin
      bit_count_next  = '0;
      shift_code_next = '0;
      receiving_next  = 1'b1;
    end else if (receiving) begin
      if (is_one) begin
        shift_code_next = shift_code | (CODE_W'(1) << bit_count);
        bit_in          = 1'b1;
      end else if (is_zero) begin
        bit_in = 1'b1;
      end else begin
        receiving_next = 1'b0;
        bit_count_next = '0;
      end
      if (bit_in) begin
        if (bit_count == '1) begin
          // Last bit of the frame: close it and check the code
          receiving_next = 1'b0;
          bit_count_next = '0;
          done = (shift_code_next != '0) && (shift_code_next != CODE_ALL_ONES);
        end else begin
          bit_count_next = bit_count + BIT_CNT_W'(1);
        end
      end
    end
  end

  assign push_cmd = '{done: done, code: shift_code_next};

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge  <= '0;
      bit_count  <= '0;
      shift_code <= '0;
      receiving  <= 1'b0;
    end else if (accept) begin
      last_edge  <= edge_ch.edge_time;
      bit_count  <= bit_count_next;
      shift_code <= shift_code_next;
      receiving  <= receiving_next;
    end
  end

  `IRRD_ASSERT_IMPLIES(a_idle_count_clear, clk, rst, !receiving, bit_count == '0, "bit count set while idle")
  `IRRD_ASSERT_IMPLIES(a_done_code_valid, clk, rst, push_valid && push_cmd.done, (push_cmd.code != '0) && (push_cmd.code != CODE_ALL_ONES), "done with rejected code")

endmodule

>>> hdl/irrd_queue.sv
`timescale 1ns / 1ps
`include "ir_remote_rgb_dimmer_macros.svh"
module irrd_queue import irrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  input  irrd_cmd_t push_cmd,
  output logic      push_ready,
  output logic      pop_valid,
  output irrd_cmd_t pop_cmd,
  input  logic      pop_ready
);

  logic [QCNT_W-1:0] count;
  irrd_cmd_t         head;
  irrd_cmd_t         tail;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = head;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Hold count; entries shift toward the head on each pop
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (push_fire && !pop_fire) begin
        count <= count + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Move payload
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      head <= (push_fire && (count == QCNT_W'(1))) ? push_cmd : tail;
      if (push_fire) begin
        tail <= push_cmd;
      end
    end else if (push_fire) begin
      if (count == '0) begin
        head <= push_cmd;
      end else begin
        tail <= push_cmd;
      end
    end
  end

  `IRRD_ASSERT_ALWAYS(a_count_range, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `IRRD_ASSERT_NEXT(a_count_steady, clk, rst, push_fire && pop_fire, $stable(count), "count moved on push with pop")

endmodule

>>> hdl/irrd_back.sv
`timescale 1ns / 1ps
`include "ir_remote_rgb_dimmer_macros.svh"
module irrd_back import irrd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  irrd_cfg_t     cfg,
  input  logic          pop_valid,
  input  irrd_cmd_t     pop_cmd,
  output logic          pop_ready,
  irrd_result_if.source result_ch
);

  logic [LEVEL_W-1:0] red_store;
  logic [LEVEL_W-1:0] green_store;
  logic [LEVEL_W-1:0] blue_store;
  logic [LEVEL_W-1:0] red_store_next;
  logic [LEVEL_W-1:0] green_store_next;
  logic [LEVEL_W-1:0] blue_store_next;

  logic               out_valid;
  logic [LEVEL_W-1:0] out_red;
  logic [LEVEL_W-1:0] out_green;
  logic [LEVEL_W-1:0] out_blue;
  logic               out_done;
  logic [CODE_W-1:0]  out_code;

  logic               fire;
  logic [LEVEL_W-1:0] cur_level;
  logic [LEVEL_W-1:0] down_level;
  logic [LEVEL_W-1:0] up_level;
  logic [LEVEL_W:0]   up_sum;

  // Take the next command whenever the output register frees up
  assign pop_ready = !out_valid || result_ch.ready;
  assign fire      = pop_valid && pop_ready;

  // Pick the channel a step key acts on
  always_comb begin
    case (pop_cmd.code)
      KEY_RED_DOWN, KEY_RED_UP:     cur_level = red_store;
      KEY_GREEN_DOWN, KEY_GREEN_UP: cur_level = green_store;
      default:                      cur_level = blue_store;
    endcase
  end

  // Step down to zero or up to the period, saturating
  assign down_level = (cur_level >= cfg.step_size) ? (cur_level - cfg.step_size) : '0;
  assign up_sum     = {1'b0, cur_level} + {1'b0, cfg.step_size};
  assign up_level   = (up_sum <= {1'b0, cfg.period_top}) ? up_sum[LEVEL_W-1:0] : cfg.period_top;

  // Apply a finished code
  always_comb begin
    red_store_next   = red_store;
    green_store_next = green_store;
    blue_store_next  = blue_store;
    if (pop_cmd.done) begin
      case (pop_cmd.code)
        KEY_RED_DOWN:   red_store_next   = down_level;
        KEY_RED_UP:     red_store_next   = up_level;
        KEY_GREEN_DOWN: green_store_next = down_level;
        KEY_GREEN_UP:   green_store_next = up_level;
        KEY_BLUE_DOWN:  blue_store_next  = down_level;
        KEY_BLUE_UP:    blue_store_next  = up_level;
        KEY_ALL_MAX: begin
          red_store_next   = cfg.period_top;
          green_store_next = cfg.period_top;
          blue_store_next  = cfg.period_top;
        end
        KEY_ALL_ZERO: begin
          red_store_next   = '0;
          green_store_next = '0;
          blue_store_next  = '0;
        end
        default: begin
          red_store_next = red_store;
        end
      endcase
    end
  end

  // Hold levels and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      red_store   <= LEVEL_RESET;
      green_store <= LEVEL_RESET;
      blue_store  <= LEVEL_RESET;
      out_valid   <= 1'b0;
    end else if (fire) begin
      red_store   <= red_store_next;
      green_store <= green_store_next;
      blue_store  <= blue_store_next;
      out_valid   <= 1'b1;
      out_red     <= red_store_next;
      out_green   <= green_store_next;
      out_blue    <= blue_store_next;
      out_done    <= pop_cmd.done;
      out_code    <= pop_cmd.code;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.red_level   = out_red;
  assign result_ch.green_level = out_green;
  assign result_ch.blue_level  = out_blue;
  assign result_ch.code_done   = out_done;
  assign result_ch.code_value  = out_code;

  `IRRD_ASSERT_NEXT(a_levels_hold, clk, rst, !(fire && pop_cmd.done), $stable(red_store) && $stable(green_store) && $stable(blue_store), "level changed without a code")

endmodule

>>> hdl/ir_remote_rgb_dimmer.sv
`timescale 1ns / 1ps
// IR remote RGB dimmer. Feed one falling-edge timer capture per transfer on
// edge_ch; every capture yields exactly one transfer on result_ch carrying the
// three PWM compare levels, a flag set when that edge completed a valid
// 32-bit code, and the current code shift register. A new capture is taken
// every cycle the queue has room: the decoder handles one edge per clock, a
// two-entry queue separates it from the level unit, and the level unit
// finishes one command per clock into its output register unless result_ch
// stalls, and the queue absorbs short stalls on result_ch. Write the eight
// 16-bit registers over APB only while no capture is in flight.
module ir_remote_rgb_dimmer import irrd_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  irrd_edge_if.sink             edge_ch,
  irrd_result_if.source         result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_IDX_W+1:0]  paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  irrd_cfg_t cfg;
  irrd_reg_t reg_sel;
  logic      cfg_write;
  logic      push_valid;
  logic      push_ready;
  irrd_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  irrd_cmd_t pop_cmd;

  assign pready    = 1'b1;
  assign reg_sel   = irrd_reg_t'(paddr[REG_IDX_W+1:2]);
  assign cfg_write = psel && penable && pwrite;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_PERIOD_TOP: cfg.period_top <= pwdata[CFG_W-1:0];
        REG_STEP_SIZE:  cfg.step_size  <= pwdata[CFG_W-1:0];
        REG_START_MIN:  cfg.start_min  <= pwdata[CFG_W-1:0];
        REG_START_MAX:  cfg.start_max  <= pwdata[CFG_W-1:0];
        REG_ONE_MIN:    cfg.one_min    <= pwdata[CFG_W-1:0];
        REG_ONE_MAX:    cfg.one_max    <= pwdata[CFG_W-1:0];
        REG_ZERO_MIN:   cfg.zero_min   <= pwdata[CFG_W-1:0];
        REG_ZERO_MAX:   cfg.zero_max   <= pwdata[CFG_W-1:0];
        default:        cfg            <= cfg;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_PERIOD_TOP: prdata = APB_DATA_W'(cfg.period_top);
      REG_STEP_SIZE:  prdata = APB_DATA_W'(cfg.step_size);
      REG_START_MIN:  prdata = APB_DATA_W'(cfg.start_min);
      REG_START_MAX:  prdata = APB_DATA_W'(cfg.start_max);
      REG_ONE_MIN:    prdata = APB_DATA_W'(cfg.one_min);
      REG_ONE_MAX:    prdata = APB_DATA_W'(cfg.one_max);
      REG_ZERO_MIN:   prdata = APB_DATA_W'(cfg.zero_min);
      REG_ZERO_MAX:   prdata = APB_DATA_W'(cfg.zero_max);
      default:        prdata = '0;
    endcase
  end

  irrd_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .edge_ch    (edge_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  irrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  irrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .result_ch (result_ch)
  );

endmodule
